FILE: hdl/assert_macros.svh
// Assertion macros shared by the serial ring pair RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

FILE: hdl/bsrp_pkg.sv
// Types, constants and helpers for the buffered serial ring pair.
`timescale 1ns / 1ps

package bsrp_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_LINE_RX  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_HOST_WR  = 2'd2,
    CMD_HOST_RD  = 2'd3
  } cmd_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        line_tx_valid;
    logic [7:0]  line_tx_byte;
    logic        host_rx_valid;
    logic [7:0]  host_rx_byte;
    logic        write_accepted;
    logic        rx_dropped;
    logic        tx_irq_enabled;
    logic [31:0] received_total;
    logic [31:0] sent_total;
  } out_item_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t n;
    n = '0;
    if (p != ptr_t'(RING_DEPTH - 1)) begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

endpackage

FILE: hdl/buffered_serial_ring_pair.sv
// Buffered serial ring pair: receive and transmit byte rings between a line and a host.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One transaction on the input channel is one event: a byte from the line, a
// transmitter-ready strobe, a host write or a host read. Each event yields exactly
// one result transaction. Each ring holds RING_DEPTH-1 bytes in a single-port-write,
// registered-read memory. Line bytes, host writes, empty reads and transmitter-ready
// on an empty ring load the result register directly; a host read or transmitter-ready
// that pulls a byte first passes through ST_READ for the registered ring memory read.
// Events are handled one at a time. The memories need no clearing after reset.
module buffered_serial_ring_pair import bsrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_mem [RING_DEPTH];

  state_t      state, state_next;
  ptr_t        rx_wr, rx_rd, tx_wr, tx_rd;
  ptr_t        rx_wr_next, rx_rd_next, tx_wr_next, tx_rd_next;
  logic        irq, irq_next;
  logic [31:0] rx_count, rx_count_next, tx_count, tx_count_next;
  logic [7:0]  rx_q, tx_q;
  cmd_t        pend_cmd;

  logic      accept;
  logic      rx_full, rx_empty, tx_full, tx_empty;
  logic      load_now, load_read;
  out_item_t res_now, res_read;

  assign in_stall = !((state == ST_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  assign rx_full  = (ring_next(rx_wr) == rx_rd);
  assign rx_empty = (rx_wr == rx_rd);
  assign tx_full  = (ring_next(tx_wr) == tx_rd);
  assign tx_empty = (tx_wr == tx_rd);

  always_comb begin
    rx_wr_next    = rx_wr;
    rx_rd_next    = rx_rd;
    tx_wr_next    = tx_wr;
    tx_rd_next    = tx_rd;
    irq_next      = irq;
    rx_count_next = rx_count;
    tx_count_next = tx_count;
    state_next    = state;
    load_now      = 1'b0;
    res_now       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_LINE_RX: begin
              if (rx_full) begin
                res_now.rx_dropped = 1'b1;
              end else begin
                rx_wr_next    = ring_next(rx_wr);
                rx_count_next = rx_count + 32'd1;
              end
              load_now = 1'b1;
            end
            CMD_TX_READY: begin
              if (!tx_empty) begin
                tx_rd_next    = ring_next(tx_rd);
                tx_count_next = tx_count + 32'd1;
                state_next    = ST_READ;
              end else begin
                load_now = 1'b1;
              end
              if (tx_rd_next == tx_wr) begin
                irq_next = 1'b0;
              end
            end
            CMD_HOST_WR: begin
              if (!tx_full) begin
                tx_wr_next             = ring_next(tx_wr);
                irq_next               = 1'b1;
                res_now.write_accepted = 1'b1;
              end
              load_now = 1'b1;
            end
            CMD_HOST_RD: begin
              if (!rx_empty) begin
                rx_rd_next = ring_next(rx_rd);
                state_next = ST_READ;
              end else begin
                load_now = 1'b1;
              end
            end
            default: begin
              load_now = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    res_now.tx_irq_enabled = irq_next;
    res_now.received_total = rx_count_next;
    res_now.sent_total     = tx_count_next;
  end

  // Result of a read that went through the ring memory; state is already updated.
  assign load_read = (state == ST_READ);

  always_comb begin
    res_read                = '0;
    res_read.tx_irq_enabled = irq;
    res_read.received_total = rx_count;
    res_read.sent_total     = tx_count;
    if (pend_cmd == CMD_TX_READY) begin
      res_read.line_tx_valid = 1'b1;
      res_read.line_tx_byte  = tx_q;
    end else begin
      res_read.host_rx_valid = 1'b1;
      res_read.host_rx_byte  = (rx_q == CHAR_CR) ? CHAR_LF : rx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.command == CMD_LINE_RX && !rx_full) begin
      rx_mem[rx_wr] <= in_data.data_byte;
    end
    if (accept && in_data.command == CMD_HOST_RD) begin
      rx_q <= rx_mem[rx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.command == CMD_HOST_WR && !tx_full) begin
      tx_mem[tx_wr] <= in_data.data_byte;
    end
    if (accept && in_data.command == CMD_TX_READY) begin
      tx_q <= tx_mem[tx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rx_wr    <= '0;
      rx_rd    <= '0;
      tx_wr    <= '0;
      tx_rd    <= '0;
      irq      <= 1'b0;
      rx_count <= '0;
      tx_count <= '0;
    end else begin
      state    <= state_next;
      rx_wr    <= rx_wr_next;
      rx_rd    <= rx_rd_next;
      tx_wr    <= tx_wr_next;
      tx_rd    <= tx_rd_next;
      irq      <= irq_next;
      rx_count <= rx_count_next;
      tx_count <= tx_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd <= in_data.command;
    end
  end

  // Output register: loaded by a finished event, freed when the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_read) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_read) begin
      out_data <= res_read;
    end else if (load_now) begin
      out_data <= res_now;
    end
  end

  `ASSERT_CLK(a_accept_idle, clk, rst, (in_valid && !in_stall) |-> (state == ST_IDLE),
    "event accepted while a memory read is pending")
  `ASSERT_CLK(a_read_slot_free, clk, rst, (state == ST_READ) |-> !out_valid,
    "output register busy when read result arrives")
  `ASSERT_CLK(a_read_completes, clk, rst, (state == ST_READ) |=> (state == ST_IDLE && out_valid),
    "memory read did not produce a result")
  `ASSERT_NEVER(a_one_load, clk, rst, load_now && load_read,
    "two results loaded in one cycle")

endmodule
